FILE: design/lfww_pkg.sv
// ----------------------------------------------------------------------------
// lfww_pkg
// Shared types and constants for the line fold word wrap unit: character
// codes, controller states, output source select and the command and status
// groups between controller and datapath.
// ----------------------------------------------------------------------------
package lfww_pkg;

    // Separator character codes
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;

    // Column counter saturates here
    localparam logic [5:0] COL_MAX = 6'd63;

    // Reset value of the line width register
    localparam logic [5:0] LINE_WIDTH_RESET = 6'd63;

    // Default word buffer depth
    localparam int MAX_WIDTH_DEF = 63;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_RD,
        S_WORD,
        S_POST1,
        S_POST2
    } state_t;

    // Source of the next output word
    typedef enum logic [1:0] {
        SRC_NL,
        SRC_WORD,
        SRC_POST1
    } src_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // take the input character, update line state
        logic load;      // load the output register
        src_t src;       // what to load
        logic last;      // final result of this character
        logic rd_start;  // read buffer entry zero
        logic rd_next;   // read the following buffer entry
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic any;        // this character causes results
        logic has_pre;    // newline ahead of the word
        logic wlen_nz;    // word to send is not empty
        logic has_post1;  // one character after the word
        logic has_post2;  // a newline after that
        logic word_end;   // entry being sent is the word's last
        logic out_free;   // output register can be loaded
    } ctl_sts_t;

endpackage

FILE: design/lfww_ram.sv
// ----------------------------------------------------------------------------
// lfww_ram
// Generic single write port, single read port RAM with registered read data.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module lfww_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/lfww_datapath.sv
// ----------------------------------------------------------------------------
// lfww_datapath
// Line state (word count, column, single word flag, line width), the word
// buffer, the per character emission plan and the output register.
// ----------------------------------------------------------------------------
module lfww_datapath
    import lfww_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  ctl_cmd_t   cmd,
    output ctl_sts_t   sts,
    input  logic [7:0] in_char,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] cfg_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       out_last
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WIDTH);
    localparam logic [5:0]    MAX_W6  = 6'(MAX_WIDTH);

    logic [5:0]    line_width_reg;
    logic [CW-1:0] wc_reg, wc_next;
    logic [5:0]    col_reg, col_next;
    logic          single_reg, single_next;

    logic          has_pre_reg, has_post1_reg, has_post2_reg;
    logic [CW-1:0] wlen_reg;
    logic [7:0]    post1_char_reg;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;

    logic          out_valid_reg;
    logic [7:0]    out_char_reg;
    logic          out_last_reg;

    logic          is_sep, is_nl, fold, store_we;
    logic [5:0]    width_eff, col_inc, col1;
    logic [CW-1:0] wc1, wlen_c;
    logic          single1;
    logic          pre_c, post1_c, post2_c;
    logic [7:0]    ram_rdata;
    logic [AW-1:0] ram_raddr;

    // Classify the character and work out the new line state and plan
    always_comb
    begin
        is_nl  = (in_char == CH_NL);
        is_sep = (in_char == CH_SPACE) || (in_char == CH_TAB) || is_nl;

        if (line_width_reg == 6'd0)
            width_eff = 6'd1;
        else if (line_width_reg > MAX_W6)
            width_eff = MAX_W6;
        else
            width_eff = line_width_reg;

        col_inc  = (col_reg < COL_MAX) ? col_reg + 6'd1 : col_reg;
        store_we = 1'b0;

        if (is_sep)
        begin
            wc1     = '0;
            col1    = is_nl ? 6'd0 : col_inc;
            single1 = is_nl;
        end
        else
        begin
            store_we = (wc_reg < MAX_CNT);
            wc1      = store_we ? wc_reg + CW'(1) : wc_reg;
            col1     = col_inc;
            single1  = single_reg;
        end

        fold = (col1 >= width_eff);

        wc_next     = wc1;
        col_next    = col1;
        single_next = single1;
        if (fold)
        begin
            wc_next     = '0;
            single_next = 1'b1;
            col_next    = single1 ? 6'd0 : 6'(wc1);
        end

        // Only one word is sent per character: after a separator the
        // fold word is empty
        wlen_c  = is_sep ? wc_reg : (fold ? wc1 : '0);
        pre_c   = !is_sep && fold && !single1;
        post1_c = is_sep || (fold && single1);
        post2_c = is_sep && fold;
    end

    // Hand the plan to the controller, fresh on the accepting cycle
    always_comb
    begin
        sts.any       = cmd.accept ? (is_sep || fold) : 1'b0;
        sts.has_pre   = cmd.accept ? pre_c : has_pre_reg;
        sts.wlen_nz   = cmd.accept ? (wlen_c != '0) : (wlen_reg != '0);
        sts.has_post1 = cmd.accept ? post1_c : has_post1_reg;
        sts.has_post2 = cmd.accept ? post2_c : has_post2_reg;
        sts.word_end  = ((CW'(rd_idx_reg) + CW'(1)) == wlen_reg);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    // Configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            line_width_reg <= cfg_data;
        end
    end

    // Line state and plan, updated when a character is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg        <= '0;
            col_reg       <= '0;
            single_reg    <= 1'b1;
            has_pre_reg   <= 1'b0;
            has_post1_reg <= 1'b0;
            has_post2_reg <= 1'b0;
            wlen_reg      <= '0;
        end
        else if (cmd.accept)
        begin
            wc_reg        <= wc_next;
            col_reg       <= col_next;
            single_reg    <= single_next;
            has_pre_reg   <= pre_c;
            has_post1_reg <= post1_c;
            has_post2_reg <= post2_c;
            wlen_reg      <= wlen_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            post1_char_reg <= is_sep ? in_char : CH_NL;
        end
    end

    // Buffer read index
    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (cmd.rd_start)
            rd_idx_next = '0;
        else if (cmd.rd_next)
            rd_idx_next = rd_idx_reg + AW'(1);
    end

    assign ram_raddr = rd_idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
        end
        else
        begin
            rd_idx_reg <= rd_idx_next;
        end
    end

    lfww_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_word_ram (
        .clk   (clk),
        .we    (cmd.accept && store_we),
        .waddr (wc_reg[AW-1:0]),
        .wdata (in_char),
        .re    (cmd.rd_start || cmd.rd_next),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_last_reg <= cmd.last;
            case (cmd.src)
                SRC_NL:    out_char_reg <= CH_NL;
                SRC_WORD:  out_char_reg <= ram_rdata;
                SRC_POST1: out_char_reg <= post1_char_reg;
                default:   out_char_reg <= CH_NL;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

    // Word count never passes the buffer depth
    a_wc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wc_reg <= MAX_CNT)
        else $error("word count beyond buffer depth");

endmodule

FILE: design/lfww_ctrl.sv
// ----------------------------------------------------------------------------
// lfww_ctrl
// Sequencer for one character: take it, then send the optional leading
// newline, the buffered word, and up to two trailing characters.
// ----------------------------------------------------------------------------
module lfww_ctrl
    import lfww_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd
);

    state_t state_reg, state_next;

    function automatic state_t after_word(input ctl_sts_t s);
        return s.has_post1 ? S_POST1 : S_IDLE;
    endfunction

    function automatic state_t after_pre(input ctl_sts_t s);
        return s.wlen_nz ? S_RD : after_word(s);
    endfunction

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.src      = SRC_NL;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.any)
                        state_next = sts.has_pre ? S_PRE : after_pre(sts);
                end
            end
            S_PRE:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.src    = SRC_NL;
                    cmd.last   = !sts.wlen_nz && !sts.has_post1;
                    state_next = after_pre(sts);
                end
            end
            S_RD:
            begin
                cmd.rd_start = 1'b1;
                state_next   = S_WORD;
            end
            S_WORD:
            begin
                if (sts.out_free)
                begin
                    cmd.load = 1'b1;
                    cmd.src  = SRC_WORD;
                    cmd.last = sts.word_end && !sts.has_post1;
                    if (sts.word_end)
                        state_next = after_word(sts);
                    else
                        cmd.rd_next = 1'b1;
                end
            end
            S_POST1:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.src    = SRC_POST1;
                    cmd.last   = !sts.has_post2;
                    state_next = sts.has_post2 ? S_POST2 : S_IDLE;
                end
            end
            S_POST2:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.src    = SRC_NL;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register is never overwritten while a character waits
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> sts.out_free)
        else $error("output loaded while occupied");

    // The final result of a character returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && cmd.last |=> state_reg == S_IDLE)
        else $error("sequencer busy after final result");

    // A word is only sent when the plan holds one
    a_word_nz: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD || state_reg == S_WORD) |-> sts.wlen_nz)
        else $error("word emission with empty word");

endmodule

FILE: design/line_fold_word_wrap_unit.sv
// ----------------------------------------------------------------------------
// line_fold_word_wrap_unit
// Greedy word wrap: folds a character stream into lines of a set width.
//
//   channel   dir  handshake              payload
//   s_axis    in   s_axis_tvalid/tready   tdata[7:0] in_char
//   m_axis    out  m_axis_tvalid/tready   tdata[7:0] out_char, tlast last
//   cfg       in   cfg_valid/cfg_ready    cfg_data[5:0] line_width
//
// A character with no result is taken in the idle state. One with results is
// accepted, passes a read state if a buffered word is sent (registered buffer
// read), then sends each result through the single output register.
// Output stalls hold the sequencer; the next character is taken while the
// final result still waits in the output register.
// Reset is asynchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module line_fold_word_wrap_unit
    import lfww_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_char
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] cfg_data        // [5:0] line_width
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    // Sequencer
    lfww_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Line state, word buffer and output register
    lfww_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_char   (s_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
